// ===== src/psirq_pkg.sv =====
// ----------------------------------------------------------------------------
// psirq_pkg
// Shared constants for the pulse/sawtooth sound unit with cycle interrupt:
// item commands, bus register slots, counter constants and config indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package psirq_pkg;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes (paddr[2])
  localparam logic CFG_SEL0 = 1'b0;
  localparam logic CFG_SEL1 = 1'b1;

  // Decoded bus register slots
  localparam logic [15:0] REG_P0_CTRL   = 16'h9000;
  localparam logic [15:0] REG_P0_PER_LO = 16'h9001;
  localparam logic [15:0] REG_P0_PER_HI = 16'h9002;
  localparam logic [15:0] REG_P1_CTRL   = 16'ha000;
  localparam logic [15:0] REG_P1_PER_LO = 16'ha001;
  localparam logic [15:0] REG_P1_PER_HI = 16'ha002;
  localparam logic [15:0] REG_SAW_RATE  = 16'hb000;
  localparam logic [15:0] REG_SAW_PER_LO = 16'hb001;
  localparam logic [15:0] REG_SAW_PER_HI = 16'hb002;
  localparam logic [15:0] REG_IRQ_LATCH = 16'hf000;
  localparam logic [15:0] REG_IRQ_CTRL  = 16'hf001;
  localparam logic [15:0] REG_IRQ_ACK   = 16'hf002;

  // Interrupt counter constants
  localparam logic [9:0] PRESCALE_PERIOD = 10'd341;
  localparam logic [9:0] PRESCALE_STEP   = 10'd3;
  localparam logic [7:0] IRQ_COUNT_TOP   = 8'hff;

  // Sawtooth stage count per cycle
  localparam logic [2:0] SAW_STAGES = 3'd7;

  // Largest channel sum
  localparam logic [5:0] AUDIO_SUM_MAX = 6'd61;

endpackage

`default_nettype wire

// ===== src/pulse_sawtooth_sound_with_cycle_irq_unit.sv =====
// An accepted item moves from the input register to the result register when free.
// Throughput: one item per cycle while out_stall is low; the input register and
// the result register form a two-stage pipe, and all state updates happen in one
// pass between them.
// Reset (synchronous, rst high): both stages empty, sound and interrupt state
// cleared, dividers at 1, select pins at bit 0 and bit 1.
// ----------------------------------------------------------------------------
// pulse_sawtooth_sound_with_cycle_irq_unit
// Two pulse channels and a sawtooth channel clocked by CPU cycle ticks, plus a
// scanline/cycle interrupt counter, all programmed by decoded bus writes.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_sawtooth_sound_with_cycle_irq_unit
  import psirq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // item input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             irq_out,
  output logic [5:0]       audio_sum,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration
  logic [3:0] reg_select_bit0_pin;
  logic [3:0] reg_select_bit1_pin;

  // Input stage
  logic        stage_valid;
  logic        stage_command;
  logic [15:0] stage_address;
  logic [7:0]  stage_data;

  // Sound and interrupt state
  logic [20:0] pulse_control [2];
  logic [11:0] pulse_divider [2];
  logic [3:0]  pulse_step    [2];
  logic [3:0]  pulse_level   [2];
  logic [18:0] saw_control;
  logic [11:0] saw_divider;
  logic [3:0]  saw_phase_and_stage;
  logic [7:0]  saw_accumulator;
  logic [4:0]  saw_level;
  logic [7:0]  irq_reload_value;
  logic [3:0]  irq_flags;
  logic [7:0]  irq_count;
  logic [9:0]  irq_prescale;

  logic [20:0] pulse_control_next [2];
  logic [11:0] pulse_divider_next [2];
  logic [3:0]  pulse_step_next    [2];
  logic [3:0]  pulse_level_next   [2];
  logic [18:0] saw_control_next;
  logic [11:0] saw_divider_next;
  logic [3:0]  saw_phase_and_stage_next;
  logic [7:0]  saw_accumulator_next;
  logic [4:0]  saw_level_next;
  logic [7:0]  irq_reload_value_next;
  logic [3:0]  irq_flags_next;
  logic [7:0]  irq_count_next;
  logic [9:0]  irq_prescale_next;

  // Combinational helpers
  logic        out_free;
  logic        stage_fire;
  logic        in_accept;
  logic [15:0] reg_slot;
  logic        irq_bump;
  logic [11:0] pulse_div_dec [2];
  logic [11:0] saw_div_dec;
  logic        saw_phase_new;
  logic [2:0]  saw_stage_new;
  logic [5:0]  sum_next;

  // Handshake
  assign out_free   = !out_valid || !out_stall;
  assign stage_fire = stage_valid && out_free;
  assign in_stall   = stage_valid && !out_free;
  assign in_accept  = in_valid && !in_stall;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == CFG_SEL1) begin
      prdata[3:0] = reg_select_bit1_pin;
    end else begin
      prdata[3:0] = reg_select_bit0_pin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_select_bit0_pin <= 4'd0;
      reg_select_bit1_pin <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == CFG_SEL0) begin
        reg_select_bit0_pin <= pwdata[3:0];
      end else begin
        reg_select_bit1_pin <= pwdata[3:0];
      end
    end
  end

  // Decode the bus register slot: top nibble plus the two selected pins
  assign reg_slot = {stage_address[15:12], 10'd0,
                     stage_address[reg_select_bit1_pin],
                     stage_address[reg_select_bit0_pin]};

  // Interrupt counter step request for a tick
  always_comb begin
    irq_bump = 1'b0;
    if (irq_flags[1]) begin
      irq_bump = irq_flags[2] || (irq_prescale <= PRESCALE_STEP);
    end
  end

  // Divider decrements
  assign pulse_div_dec[0] = pulse_divider[0] - 12'd1;
  assign pulse_div_dec[1] = pulse_divider[1] - 12'd1;
  assign saw_div_dec      = saw_divider - 12'd1;
  assign saw_phase_new    = ~saw_phase_and_stage[0];

  // Next state for one item
  always_comb begin
    pulse_control_next       = pulse_control;
    pulse_divider_next       = pulse_divider;
    pulse_step_next          = pulse_step;
    pulse_level_next         = pulse_level;
    saw_control_next         = saw_control;
    saw_divider_next         = saw_divider;
    saw_phase_and_stage_next = saw_phase_and_stage;
    saw_accumulator_next     = saw_accumulator;
    saw_level_next           = saw_level;
    irq_reload_value_next    = irq_reload_value;
    irq_flags_next           = irq_flags;
    irq_count_next           = irq_count;
    irq_prescale_next        = irq_prescale;
    saw_stage_new            = saw_phase_and_stage[3:1];

    if (stage_fire && stage_command == CMD_WRITE) begin
      // Bus write: only the upper half of the address space is decoded
      if (stage_address[15]) begin
        case (reg_slot)
          REG_P0_CTRL:    pulse_control_next[0][7:0]  = stage_data;
          REG_P1_CTRL:    pulse_control_next[1][7:0]  = stage_data;
          REG_P0_PER_LO:  pulse_control_next[0][16:9] = stage_data;
          REG_P1_PER_LO:  pulse_control_next[1][16:9] = stage_data;
          REG_P0_PER_HI: begin
            pulse_control_next[0][20:17] = stage_data[3:0];
            pulse_control_next[0][8]     = stage_data[7];
          end
          REG_P1_PER_HI: begin
            pulse_control_next[1][20:17] = stage_data[3:0];
            pulse_control_next[1][8]     = stage_data[7];
          end
          REG_SAW_RATE:   saw_control_next[5:0]  = stage_data[5:0];
          REG_SAW_PER_LO: saw_control_next[14:7] = stage_data;
          REG_SAW_PER_HI: begin
            saw_control_next[18:15] = stage_data[3:0];
            saw_control_next[6]     = stage_data[7];
          end
          REG_IRQ_LATCH:  irq_reload_value_next = stage_data;
          REG_IRQ_CTRL: begin
            irq_flags_next = {1'b0, stage_data[2:0]};
            if (stage_data[1]) begin
              irq_count_next    = irq_reload_value;
              irq_prescale_next = PRESCALE_PERIOD;
            end
          end
          REG_IRQ_ACK: begin
            // Copy acknowledge into enable and drop the line
            irq_flags_next = {1'b0, irq_flags[2], irq_flags[0], irq_flags[0]};
          end
          default: ;
        endcase
      end
    end else if (stage_fire) begin
      // Tick: advance the scanline prescaler
      if (irq_flags[1] && !irq_flags[2]) begin
        if (irq_prescale <= PRESCALE_STEP) begin
          irq_prescale_next = irq_prescale + (PRESCALE_PERIOD - PRESCALE_STEP);
        end else begin
          irq_prescale_next = irq_prescale - PRESCALE_STEP;
        end
      end
      // Step the counter; reload and raise the line past the top
      if (irq_bump) begin
        if (irq_count == IRQ_COUNT_TOP) begin
          irq_count_next    = irq_reload_value;
          irq_flags_next[3] = 1'b1;
        end else begin
          irq_count_next = irq_count + 8'd1;
        end
      end

      // Clock both pulse channels
      for (int ch = 0; ch < 2; ch++) begin
        if (pulse_div_dec[ch] == 12'd0) begin
          pulse_divider_next[ch] = pulse_control[ch][20:9] + 12'd1;
          pulse_step_next[ch]    = pulse_step[ch] + 4'd1;
          if (pulse_control[ch][7] ||
              (pulse_step_next[ch] > {1'b0, pulse_control[ch][6:4]})) begin
            pulse_level_next[ch] = pulse_control[ch][3:0];
          end else begin
            pulse_level_next[ch] = 4'd0;
          end
        end else begin
          pulse_divider_next[ch] = pulse_div_dec[ch];
        end
        if (!pulse_control[ch][8]) begin
          pulse_level_next[ch] = 4'd0;
        end
      end

      // Clock the sawtooth: accumulate on every second divider expiry
      if (saw_div_dec == 12'd0) begin
        saw_divider_next = saw_control[18:7] + 12'd1;
        if (!saw_phase_new) begin
          saw_accumulator_next = saw_accumulator + {2'b00, saw_control[5:0]};
          saw_stage_new        = saw_phase_and_stage[3:1] + 3'd1;
          if (saw_stage_new == SAW_STAGES) begin
            saw_stage_new        = 3'd0;
            saw_accumulator_next = 8'd0;
          end
        end
        saw_phase_and_stage_next = {saw_stage_new, saw_phase_new};
      end else begin
        saw_divider_next = saw_div_dec;
      end
      saw_level_next = saw_control[6] ? saw_accumulator_next[7:3] : 5'd0;
    end
  end

  // Raw channel sum after this item
  assign sum_next = {2'b00, pulse_level_next[0]} + {2'b00, pulse_level_next[1]}
                  + {1'b0, saw_level_next};

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_control       <= '{default: 21'd0};
      pulse_divider       <= '{default: 12'd1};
      pulse_step          <= '{default: 4'd0};
      pulse_level         <= '{default: 4'd0};
      saw_control         <= 19'd0;
      saw_divider         <= 12'd1;
      saw_phase_and_stage <= 4'd0;
      saw_accumulator     <= 8'd0;
      saw_level           <= 5'd0;
      irq_reload_value    <= 8'd0;
      irq_flags           <= 4'd0;
      irq_count           <= 8'd0;
      irq_prescale        <= 10'd0;
    end else begin
      pulse_control       <= pulse_control_next;
      pulse_divider       <= pulse_divider_next;
      pulse_step          <= pulse_step_next;
      pulse_level         <= pulse_level_next;
      saw_control         <= saw_control_next;
      saw_divider         <= saw_divider_next;
      saw_phase_and_stage <= saw_phase_and_stage_next;
      saw_accumulator     <= saw_accumulator_next;
      saw_level           <= saw_level_next;
      irq_reload_value    <= irq_reload_value_next;
      irq_flags           <= irq_flags_next;
      irq_count           <= irq_count_next;
      irq_prescale        <= irq_prescale_next;
    end
  end

  // Input stage: hold the item until the result register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_command <= command;
      stage_address <= address;
      stage_data    <= data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      irq_out   <= irq_flags_next[3];
      audio_sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/psirq_checker.sv =====
// ----------------------------------------------------------------------------
// psirq_checker
// Port-level checks for the pulse/sawtooth sound unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psirq_checker
  import psirq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        irq_out,
  input wire logic [5:0]  audio_sum
);

  // Both stages come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  // The input side never stalls while the result register is empty
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // The channel sum stays within the reachable range
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> audio_sum <= AUDIO_SUM_MAX)
    else $error("channel sum out of range");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(audio_sum) && $stable(irq_out))
    else $error("stalled result changed");

endmodule

bind pulse_sawtooth_sound_with_cycle_irq_unit psirq_checker u_psirq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .irq_out   (irq_out),
  .audio_sum (audio_sum)
);

`default_nettype wire
